FILE: src/akf_pkg.sv
package akf_pkg;
	localparam int FRAC_BITS = 16;
	localparam int WORD_BITS = 32;
	localparam logic signed [WORD_BITS-1:0] WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
	localparam logic signed [WORD_BITS-1:0] WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic signed [WORD_BITS-1:0] ONE = WORD_BITS'(64'sd1 <<< FRAC_BITS);

	typedef enum logic [1:0] {
		REG_INIT_ALT = 2'd0,
		REG_Q_POS    = 2'd1,
		REG_Q_VEL    = 2'd2,
		REG_R_MEAS   = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_MDT = 2'd1,
		OP_DIV = 2'd2
	} op_t;

	typedef struct packed {
		logic                        start;
		op_t                         op;
		logic signed [WORD_BITS-1:0] a;
		logic signed [WORD_BITS-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic                        done;
		logic signed [WORD_BITS-1:0] res;
	} alu_rsp_t;

	function automatic logic signed [WORD_BITS-1:0] sat_add(
		input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
		return s[WORD_BITS-1:0];
	endfunction

	function automatic logic signed [WORD_BITS-1:0] sat_sub(
		input logic signed [WORD_BITS-1:0] a, input logic signed [WORD_BITS-1:0] b);
		logic signed [WORD_BITS:0] s;
		s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
		if (s[WORD_BITS] != s[WORD_BITS-1]) return s[WORD_BITS] ? WMIN : WMAX;
		return s[WORD_BITS-1:0];
	endfunction
endpackage

FILE: src/akf_alu.sv
module akf_alu import akf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	localparam int W = WORD_BITS;
	localparam int PW = 2 * W;
	localparam int DN = W + FRAC_BITS;
	localparam int CW = $clog2(DN + 1);
	localparam logic [W:0] LIM = {2'b01, {(W-1){1'b0}}};

	typedef enum logic [2:0] {S_IDLE, S_MUL, S_MFIN, S_DIV, S_OUT} st_t;

	st_t st_q;
	op_t op_q;
	logic neg_q;
	logic [W-1:0] ma_q, mb_q;
	logic [PW-1:0] prod_q;
	logic [DN-1:0] num_q;
	logic [W:0] rem_q;
	logic [W:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic signed [W-1:0] res_q;

	logic [W-1:0] ma, mb;
	logic [W:0] rsh, rsub;
	logic [W+1:0] qsh;
	logic [PW-FRAC_BITS:0] qm;
	logic [PW-16:0] qd;

	assign ma = req.a[W-1] ? W'(-req.a) : W'(req.a);
	assign mb = req.b[W-1] ? W'(-req.b) : W'(req.b);
	assign rsh = {rem_q[W-1:0], num_q[DN-1]};
	assign rsub = rsh - {1'b0, mb_q};
	assign qsh = {quo_q, (rsh >= {1'b0, mb_q})};
	assign qm = (PW-FRAC_BITS+1)'(({1'b0, prod_q} + ((PW+1)'(1) << (FRAC_BITS - 1)))
		>> FRAC_BITS);
	assign qd = (PW-15)'(({1'b0, prod_q} + (PW+1)'(32768)) >> 16);

	function automatic logic signed [W-1:0] fmag(input logic [PW:0] m, input logic n);
		if (n) return (m > {{(PW-W){1'b0}}, LIM}) ? WMIN : W'(-m);
		return (m > {{(PW-W+1){1'b0}}, WMAX}) ? WMAX : W'(m);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			case (st_q)
				S_IDLE: if (req.start) begin
					op_q <= req.op;
					ma_q <= ma;
					mb_q <= (req.op == OP_MDT) ? {{(W-16){1'b0}}, req.b[15:0]} : mb;
					neg_q <= (req.op == OP_MDT) ? req.a[W-1] : (req.a[W-1] ^ req.b[W-1]);
					num_q <= {ma, {FRAC_BITS{1'b0}}};
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= CW'(DN);
					if (req.op == OP_DIV) st_q <= (mb == '0) ? S_OUT : S_DIV;
					else st_q <= S_MUL;
					res_q <= '0;
				end
				S_MUL: begin
					prod_q <= PW'(ma_q) * PW'(mb_q);
					st_q <= S_MFIN;
				end
				S_MFIN: begin
					if (op_q == OP_MDT)
						res_q <= fmag((PW+1)'(qd), neg_q);
					else
						res_q <= fmag((PW+1)'(qm), neg_q);
					st_q <= S_OUT;
				end
				S_DIV: begin
					rem_q <= (rsh >= {1'b0, mb_q}) ? rsub : rsh;
					quo_q <= (qsh > {1'b0, LIM}) ? LIM + 1'b1 : qsh[W:0];
					num_q <= num_q << 1;
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						st_q <= S_OUT;
						res_q <= fmag((PW+1)'((qsh > {1'b0, LIM}) ? LIM + 1'b1 : qsh[W:0]),
							neg_q);
					end
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.done = (st_q == S_OUT);
	assign rsp.res = res_q;
endmodule

FILE: src/altitude_kalman_filter_core.sv
// Altitude Kalman filter core, two states, constant-velocity model.
// Input channel: in_valid / in_stall carry measured_altitude (Q16.16)
// and time_step (2^-16 s). Output channel: out_valid / out_stall carry
// altitude_estimate and velocity_estimate (Q16.16, saturated).
// Configuration: cfg_we, cfg_index, cfg_data; write only while idle.
// Writing initial_altitude reloads the state and sets covariance to identity.
// One request runs through 13 operations on a single shared arithmetic
// unit: multiplies pass through a product state and a rounding state,
// divides produce one quotient bit per cycle, and a zero divisor skips
// the division and gives zero. A new request is accepted only after
// the result of the last one has been taken.
// in_stall is high from accept until the result has been taken.
// A result waits in the output register while out_stall is high; the
// state is already updated then, and the next request is accepted only
// once the result has left.
// Reset loads altitude zero, velocity zero, identity covariance and the
// register reset values.
module altitude_kalman_filter_core import akf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   measured_altitude,
	input  logic [15:0]          time_step,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   altitude_estimate,
	output logic signed [31:0]   velocity_estimate,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);
	typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_OUT} st_t;
	typedef logic signed [WORD_BITS-1:0] w_t;

	st_t st_q;
	logic [4:0] step_q;
	alu_req_t req;
	alu_rsp_t rsp;
	w_t init_q, qp_q, qv_q, r_q;
	w_t z_q, v_q, pp_q, pv_q, vp_q, vv_q;
	w_t meas_q, pz_q, p00_q, p01_q, p10_q, p11_q, y_q, s_q, k0_q, k1_q, t_q;
	logic [15:0] dt_q;

	akf_alu u_alu (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	function automatic w_t sx(input logic [31:0] v);
		return w_t'($signed(v));
	endfunction
	function automatic w_t zx(input logic [23:0] v);
		return w_t'({1'b0, v});
	endfunction

	always_comb begin
		req.start = (st_q == S_ISSUE);
		req.op = OP_MUL;
		req.a = '0;
		req.b = w_t'({1'b0, dt_q});
		case (step_q)
			5'd0: begin req.op = OP_MDT; req.a = v_q; end
			5'd1: begin req.op = OP_MDT; req.a = sat_add(vp_q, pv_q); end
			5'd2: begin req.op = OP_MDT; req.a = vv_q; end
			5'd3: begin req.op = OP_MDT; req.a = t_q; end
			5'd4: begin req.op = OP_MDT; req.a = vv_q; end
			5'd5: begin req.op = OP_DIV; req.a = p00_q; req.b = s_q; end
			5'd6: begin req.op = OP_DIV; req.a = p10_q; req.b = s_q; end
			5'd7: begin req.a = k0_q; req.b = y_q; end
			5'd8: begin req.a = k1_q; req.b = y_q; end
			5'd9: begin req.a = sat_sub(ONE, k0_q); req.b = p00_q; end
			5'd10: begin req.a = sat_sub(ONE, k0_q); req.b = p01_q; end
			5'd11: begin req.a = k1_q; req.b = p00_q; end
			5'd12: begin req.a = k1_q; req.b = p01_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			step_q <= '0;
			init_q <= '0; qp_q <= w_t'(655); qv_q <= w_t'(6554); r_q <= w_t'(16384);
			z_q <= '0; v_q <= '0; pp_q <= ONE; pv_q <= '0; vp_q <= '0; vv_q <= ONE;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_INIT_ALT: begin
						init_q <= sx(cfg_data); z_q <= sx(cfg_data); v_q <= '0;
						pp_q <= ONE; pv_q <= '0; vp_q <= '0; vv_q <= ONE;
					end
					REG_Q_POS: qp_q <= zx(cfg_data[23:0]);
					REG_Q_VEL: qv_q <= zx(cfg_data[23:0]);
					REG_R_MEAS: r_q <= zx(cfg_data[23:0]);
					default: ;
				endcase
			end
			case (st_q)
				S_IDLE: if (in_valid) begin
					meas_q <= sx(measured_altitude);
					dt_q <= time_step;
					step_q <= '0;
					st_q <= S_ISSUE;
				end
				S_ISSUE: st_q <= S_WAIT;
				S_WAIT: if (rsp.done) begin
					st_q <= S_ISSUE;
					step_q <= step_q + 1'b1;
					case (step_q)
						5'd0: begin
							pz_q <= sat_add(z_q, rsp.res);
							y_q <= sat_sub(meas_q, sat_add(z_q, rsp.res));
						end
						5'd1: p00_q <= sat_add(pp_q, rsp.res);
						5'd2: t_q <= rsp.res;
						5'd3: begin
							p00_q <= sat_add(sat_add(p00_q, rsp.res), qp_q);
							s_q <= sat_add(sat_add(sat_add(p00_q, rsp.res), qp_q), r_q);
						end
						5'd4: begin
							p01_q <= sat_add(pv_q, rsp.res);
							p10_q <= sat_add(vp_q, rsp.res);
							p11_q <= sat_add(vv_q, qv_q);
						end
						5'd5: k0_q <= rsp.res;
						5'd6: k1_q <= rsp.res;
						5'd7: z_q <= sat_add(pz_q, rsp.res);
						5'd8: v_q <= sat_add(v_q, rsp.res);
						5'd9: pp_q <= rsp.res;
						5'd10: pv_q <= rsp.res;
						5'd11: vp_q <= sat_sub(p10_q, rsp.res);
						5'd12: begin
							vv_q <= sat_sub(p11_q, rsp.res);
							st_q <= S_OUT;
						end
						default: ;
					endcase
				end
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);
	assign altitude_estimate = z_q;
	assign velocity_estimate = v_q;

	logic unused_init;
	assign unused_init = ^init_q;

	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result shown while accepting");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(altitude_estimate))
		else $error("result dropped under stall");
	a_issue: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> st_q == S_WAIT) else $error("unit done while not waiting");
endmodule
